FILE: rtl/cef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cef_pkg
// Shared types, constants and kernel tables of the 3x3 edge/emboss filter.
// ----------------------------------------------------------------------------
package cef_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 16;
  localparam int WID_W     = 12;
  localparam int MODE_W    = 2;
  localparam int RGB_W     = 24;
  localparam int TAPS      = 9;
  localparam int SUM_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] HEIGHT_RST = 16'd2048;
  localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

  // weight of tap dx*3+dy, one row per mode; the unused mode is all zero
  localparam logic signed [4:0] KERNEL [4][TAPS] = '{
    '{5'sd0,  5'sd0,  5'sd0,  -5'sd1, 5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8,  -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{-5'sd2, -5'sd1, 5'sd0,  -5'sd1, 5'sd1,  5'sd1,  5'sd0,  5'sd1,  5'sd2},
    '{5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0}
  };

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [WID_W-1:0]  width;
    logic [ROW_W-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [TAPS-1:0][RGB_W-1:0] taps;
    logic [COL_W-1:0]           x;
    logic [ROW_W-1:0]           y;
    logic                       last;
  } work_t;

  function automatic logic signed [SUM_W-1:0] mul_tap(logic signed [4:0] w, logic [7:0] v);
    logic signed [SUM_W-1:0]   we;
    logic signed [SUM_W-1:0]   ve;
    logic signed [2*SUM_W-1:0] p;
    we = {{(SUM_W-5){w[4]}}, w};
    ve = {{(SUM_W-8){1'b0}}, v};
    p  = we * ve;
    return p[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cef_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cef_front
// Pixel intake: position counters, line store, 3x3 window and border check.
// ----------------------------------------------------------------------------
module cef_front import cef_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             pixel_valid_i,
  output logic                  pixel_ready_o,
  input  wire logic [31:0]      pixel_argb_i,
  output logic                  push_o,
  output work_t                 work_o,
  input  wire logic             q_ready_i
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [2*RGB_W-1:0] line_mem [MAX_WIDTH];
  logic [2*RGB_W-1:0] line_rd_q;
  logic [2:0][1:0][RGB_W-1:0] win_q, win_d;
  logic [2:0][RGB_W-1:0] col_now;
  logic [WID_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [WID_W-1:0] col_ext;
  logic [WID_W-1:0] col_inc;
  logic [ROW_W:0]   row_inc;
  logic             accept;
  logic             emit;

  assign pixel_ready_o = q_ready_i;
  assign accept        = pixel_valid_i & q_ready_i;

  always_comb begin
    if (cfg_i.width < WID_W'(3)) begin
      eff_w = WID_W'(3);
    end else if (cfg_i.width > WID_W'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = cfg_i.width;
    end
    eff_h = (cfg_i.height < ROW_W'(3)) ? ROW_W'(3) : cfg_i.height;
  end

  assign col_ext = {{(WID_W-COL_W){1'b0}}, col_q};
  assign col_inc = col_ext + WID_W'(1);
  assign row_inc = {1'b0, row_q} + (ROW_W+1)'(1);

  // line store entry: {row r-2, row r-1}
  assign col_now[0] = line_rd_q[2*RGB_W-1:RGB_W];
  assign col_now[1] = line_rd_q[RGB_W-1:0];
  assign col_now[2] = pixel_argb_i[RGB_W-1:0];

  assign emit = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2)) &&
                (col_ext < eff_w) && (row_q < eff_h);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    win_d = win_q;
    if (accept) begin
      for (int dy = 0; dy < 3; dy++) begin
        win_d[dy][0] = win_q[dy][1];
        win_d[dy][1] = col_now[dy];
      end
      if (col_inc >= eff_w) begin
        col_d = '0;
        row_d = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[COL_W-1:0];
        if (row_q >= eff_h) begin
          row_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // read ahead at the next column; never the column written in the same cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col_q] <= {line_rd_q[RGB_W-1:0], pixel_argb_i[RGB_W-1:0]};
    end
    line_rd_q <= line_mem[col_d];
    win_q     <= win_d;
  end

  always_comb begin
    work_o      = '0;
    work_o.mode = cfg_i.mode;
    for (int dy = 0; dy < 3; dy++) begin
      work_o.taps[dy]     = win_q[dy][0];
      work_o.taps[3 + dy] = win_q[dy][1];
      work_o.taps[6 + dy] = col_now[dy];
    end
    work_o.x    = col_q - COL_W'(1);
    work_o.y    = row_q - ROW_W'(1);
    work_o.last = (col_ext == eff_w - WID_W'(1)) && (row_q == eff_h - ROW_W'(1));
  end

  assign push_o = accept & emit;

endmodule
`default_nettype wire

FILE: rtl/cef_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cef_queue
// Two-entry queue of window beats between intake and arithmetic.
// ----------------------------------------------------------------------------
module cef_queue import cef_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire work_t data_i,
  output logic       ready_o,
  output logic       valid_o,
  output work_t      data_o,
  input  wire logic  pop_i
);

  work_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cef_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cef_back
// Kernel arithmetic: column partial sums, final sum, clamp and output beat.
// ----------------------------------------------------------------------------
module cef_back import cef_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire work_t       q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_argb_o,
  output logic [COL_W-1:0] out_x_o,
  output logic [ROW_W-1:0] out_y_o,
  output logic             out_last_o
);

  typedef struct packed {
    logic [2:0][2:0][SUM_W-1:0] part;  // [channel][dx]
    logic [COL_W-1:0]           x;
    logic [ROW_W-1:0]           y;
    logic                       last;
  } stage_t;

  logic   s1_valid_q, s1_valid_d;
  stage_t s1_q, s1_d;
  logic   out_valid_q, out_valid_d;
  logic   out_adv;
  logic   s1_take;
  logic [23:0] rgb;
  logic [31:0] argb_q;
  logic [COL_W-1:0] x_q;
  logic [ROW_W-1:0] y_q;
  logic             last_q;

  assign out_adv = ~out_valid_q | out_ready_i;
  assign s1_take = ~s1_valid_q | out_adv;
  assign q_pop_o = q_valid_i & s1_take;

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    s1_d      = s1_q;
    s1_d.x    = q_data_i.x;
    s1_d.y    = q_data_i.y;
    s1_d.last = q_data_i.last;
    for (int ch = 0; ch < 3; ch++) begin
      for (int dx = 0; dx < 3; dx++) begin
        acc = '0;
        for (int dy = 0; dy < 3; dy++) begin
          acc = acc + mul_tap(KERNEL[q_data_i.mode][dx*3 + dy],
                              q_data_i.taps[dx*3 + dy][ch*8 +: 8]);
        end
        s1_d.part[ch][dx] = acc;
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] tot;
    rgb = '0;
    for (int ch = 0; ch < 3; ch++) begin
      tot = $signed(s1_q.part[ch][0]) + $signed(s1_q.part[ch][1]) +
            $signed(s1_q.part[ch][2]);
      if (tot[SUM_W-1]) begin
        rgb[ch*8 +: 8] = 8'd0;
      end else if (tot > SUM_W'(255)) begin
        rgb[ch*8 +: 8] = 8'hFF;
      end else begin
        rgb[ch*8 +: 8] = tot[7:0];
      end
    end
  end

  always_comb begin
    s1_valid_d  = s1_take ? q_valid_i : s1_valid_q;
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q <= s1_d;
    end
    if (out_adv && s1_valid_q) begin
      argb_q <= {ALPHA_OPAQUE, rgb};
      x_q    <= s1_q.x;
      y_q    <= s1_q.y;
      last_q <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_argb_o  = argb_q;
  assign out_x_o     = x_q;
  assign out_y_o     = y_q;
  assign out_last_o  = last_q;

endmodule
`default_nettype wire

FILE: rtl/conv3x3_edge_emboss_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_edge_emboss_filter
// 3x3 edge enhance / edge detect / emboss filter on a raster ARGB stream.
//
// Pixels enter on the pixel channel (valid/ready) in raster order. The block
// has a two-row line store and a 3x3 window; for each interior pixel it sends
// one beat on the out channel with clamped RGB, alpha 0xFF, the window
// center coordinates and a last flag on the final interior pixel of a frame.
// Border pixels are consumed and give no beat.
// Throughput: one pixel per cycle while the queue has room. A result passes
// the queue, the partial-sum register and the output register. The line store
// is read one column ahead of the column being written, so intake never waits
// on it. The user writes configuration (filter mode, width, height) through
// cfg_we_i, cfg_idx_i, cfg_data_i only while the stream is idle; the block
// does not enforce this. Reset clears the position counters and the pipeline
// valids, and restores mode 0, width 2048, height 2048; line store contents
// start undefined. When the receiver stalls, a two-entry queue and the
// arithmetic stages fill, then pixel_ready_o drops until out_ready_i returns.
// ----------------------------------------------------------------------------
module conv3x3_edge_emboss_filter import cef_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                 pixel_valid_i,
  output logic                      pixel_ready_o,
  input  wire logic [31:0]          pixel_argb_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [31:0]               out_argb_o,
  output logic [COL_W-1:0]          out_x_o,
  output logic [ROW_W-1:0]          out_y_o,
  output logic                      out_last_o
);

  cfg_t  cfg_q, cfg_d;
  logic  push;
  work_t work_in;
  logic  q_ready;
  logic  q_valid;
  work_t q_data;
  logic  q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER_MODE:  cfg_d.mode   = cfg_data_i[MODE_W-1:0];
        CFG_IMAGE_WIDTH:  cfg_d.width  = cfg_data_i[WID_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_d.height = cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= '0;
      cfg_q.width  <= WIDTH_RST;
      cfg_q.height <= HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cef_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_argb_i  (pixel_argb_i),
    .push_o        (push),
    .work_o        (work_in),
    .q_ready_i     (q_ready)
  );

  cef_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  cef_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_argb_o  (out_argb_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_last_o  (out_last_o)
  );

endmodule
`default_nettype wire
